// File: hdl/pbo_pkg.sv
// pbo_pkg: shared constants, types and the quarter-wave sine table for the
// polyblep oscillator. No dependencies; every other file in hdl/ uses it.
package pbo_pkg;

  localparam int PHASE_BITS = 24;
  localparam int PW_BITS    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int Q_FRAC     = 30;
  localparam int Q_SHIFT    = Q_FRAC - PHASE_BITS;
  localparam int PW_SHIFT   = PHASE_BITS - PW_BITS;
  localparam int ACC_W      = 36;
  localparam int MUL_W      = 32;
  localparam int DIV_STEPS  = Q_FRAC;

  localparam logic [PHASE_BITS-1:0] PH_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS:0]   PH_ONE  = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] ONE_Q30 = ACC_W'(1) <<< Q_FRAC;

  localparam logic [PW_BITS-1:0] PW_MIN   = 16'd3277;
  localparam logic [PW_BITS-1:0] PW_MAX   = 16'd62259;
  localparam logic [PW_BITS-1:0] TRI_GAIN = 16'd52429;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    SHAPE_SAW   = 2'd0,
    SHAPE_PULSE = 2'd1,
    SHAPE_TRI   = 2'd2,
    SHAPE_SINE  = 2'd3
  } shape_t;

  typedef struct packed {
    logic                  start;
    logic [PHASE_BITS-1:0] num;
    logic [PHASE_BITS-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_op_t;

  typedef logic [SINE_DEPTH-1:0][SAMPLE_W-1:0] sine_rom_t;

  // quarter sine in q1.15, taylor series in q2.30 with truncated products
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    rom = '0;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = ((x * x2) >> 30) / 64'd6;      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd506; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd600; sum = sum + $signed(term);
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) sum = 64'sd32767;
      rom[SINE_IDX_W'(i)] = sum[SAMPLE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: hdl/pbo_if.sv
// channel interfaces of the polyblep oscillator: tick requests, audio results
// and the configuration write channel. Depends on pbo_pkg.
interface pbo_tick_if;
  logic                            valid;
  logic                            ready;
  logic [pbo_pkg::PHASE_BITS-1:0]  phase_increment;
  logic [pbo_pkg::PW_BITS-1:0]     pulse_width;
  logic                            sync_reset;
  modport source (output valid, phase_increment, pulse_width, sync_reset, input ready);
  modport sink   (input valid, phase_increment, pulse_width, sync_reset, output ready);
endinterface

interface pbo_audio_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbo_pkg::SAMPLE_W-1:0] sample;
  logic                                phase_wrapped;
  modport source (output valid, sample, phase_wrapped, input ready);
  modport sink   (input valid, sample, phase_wrapped, output ready);
endinterface

interface pbo_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/pbo_div.sv
// pbo_div: restoring divider, one quotient bit per cycle, computes
// floor(num * 2^30 / den) for num < den. Depends on pbo_pkg.
module pbo_div (
  input  logic                        clk,
  input  logic                        rst,
  input  pbo_pkg::div_cmd_t           cmd,
  output pbo_pkg::div_stat_t          stat,
  output logic [pbo_pkg::Q_FRAC-1:0]  quot
);

  localparam int PB    = pbo_pkg::PHASE_BITS;
  localparam int CNT_W = $clog2(pbo_pkg::DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [PB-1:0]    rem;
  logic [PB-1:0]    den;
  logic [PB:0]      rem2;
  logic [PB:0]      diff;
  logic             take;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign take = rem2 >= {1'b0, den};

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt <= CNT_W'(pbo_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= cmd.num;
      den  <= cmd.den;
      quot <= '0;
    end else if (cnt != '0) begin
      rem  <= take ? diff[PB-1:0] : rem2[PB-1:0];
      quot <= {quot[pbo_pkg::Q_FRAC-2:0], take};
    end
  end

endmodule

// File: hdl/pbo_mul.sv
// pbo_mul: shared unsigned 32x32 multiplier with a registered product.
// Depends on pbo_pkg.
module pbo_mul (
  input  logic                         clk,
  input  pbo_pkg::mul_op_t             op,
  output logic [2*pbo_pkg::MUL_W-1:0]  prod
);

  localparam int PW = 2 * pbo_pkg::MUL_W;

  always_ff @(posedge clk) begin
    prod <= PW'(op.a) * PW'(op.b);
  end

endmodule

// File: hdl/pbo_sine.sv
// pbo_sine: quadrant decode and registered read of the quarter-wave table.
// Depends on pbo_pkg (SINE_ROM).
module pbo_sine (
  input  logic                                clk,
  input  logic [pbo_pkg::PHASE_BITS-1:0]      phase,
  output logic signed [pbo_pkg::SAMPLE_W-1:0] value
);

  localparam int PB    = pbo_pkg::PHASE_BITS;
  localparam int QBITS = PB - 2;
  localparam int IW    = pbo_pkg::SINE_IDX_W;

  logic [1:0]                          quad;
  logic [IW-1:0]                       j;
  logic [IW-1:0]                       k;
  logic signed [pbo_pkg::SAMPLE_W-1:0] mag;

  assign quad = phase[PB-1 -: 2];
  assign j    = phase[QBITS-1 -: IW];
  // mirrored index, depth minus j wraps to zero only for j == 0
  assign k    = '0 - j;

  always_comb begin
    if (quad[0]) begin
      mag = (j == '0) ? pbo_pkg::SAMPLE_MAX : $signed(pbo_pkg::SINE_ROM[k]);
    end else begin
      mag = $signed(pbo_pkg::SINE_ROM[j]);
    end
  end

  always_ff @(posedge clk) begin
    value <= quad[1] ? -mag : mag;
  end

endmodule

// File: hdl/polyblep_oscillator.sv
// polyblep_oscillator: top level, sequencer and datapath of the oscillator.
// Depends on pbo_pkg, pbo_if, pbo_div, pbo_mul and pbo_sine.
//
// One tick request in, one audio sample out. The tick carries a q0.24 phase
// increment (clamped to half a cycle), a q0.16 pulse width (clamped to
// 0.05..0.95) and a sync flag that zeroes the phase before rendering. The
// cfg channel writes the 2-bit shape (saw, pulse, triangle, sine); write it
// only while no tick is in flight. Saw and pulse use two-point polyblep edge
// correction, triangle leaky-integrates a corrected square and scales by
// 0.8, sine reads a 256-entry quarter-wave table. The output is q1.15,
// rounded half away from zero and saturated; phase_wrapped flags the wrap of
// phase plus increment. Work is done one tick at a time: tick.ready is high
// only while the sequencer is idle. Saw, pulse and triangle run a slot step
// for each edge; an edge that needs a correction runs the 30-step shared
// divider, then one pass of the shared multiplier, and triangle then adds
// its integrator and gain steps. A finished result waits in the output
// register while the next tick is accepted.
module polyblep_oscillator (
  input  logic        clk,
  input  logic        rst,
  pbo_cfg_if.sink     cfg,
  pbo_tick_if.sink    tick,
  pbo_audio_if.source audio
);

  localparam int PB     = pbo_pkg::PHASE_BITS;
  localparam int AW     = pbo_pkg::ACC_W;
  localparam int QF     = pbo_pkg::Q_FRAC;
  localparam int SW     = pbo_pkg::SAMPLE_W;
  localparam int MW     = pbo_pkg::MUL_W;
  localparam int TRI_W  = 32;
  // |square - integrator| stays below 5 * 2^30
  localparam int MAG_W  = 33;
  localparam int LO_W   = 16;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PLO_W  = PB + LO_W;
  localparam int PT_W   = PB + MAG_W;
  // 4 * dt in q2.30 is dt << (2 + Q_SHIFT), so round by the rest of 30
  localparam int TRI_SH = QF - 2 - pbo_pkg::Q_SHIFT;
  localparam int RND_W  = PT_W - TRI_SH;
  localparam int GAIN_SH = 16;
  localparam int G_W    = TRI_W + pbo_pkg::PW_BITS - GAIN_SH;
  localparam int MQ_W   = AW - 15;

  localparam logic signed [AW-1:0] TRI_MAX = AW'(32'sh7fffffff);
  localparam logic signed [AW-1:0] TRI_MIN = AW'(32'sh80000000);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_SLOT = 12'b0000_0000_0010,
    ST_DIV  = 12'b0000_0000_0100,
    ST_SQR  = 12'b0000_0000_1000,
    ST_ACC  = 12'b0000_0001_0000,
    ST_TLO  = 12'b0000_0010_0000,
    ST_THI  = 12'b0000_0100_0000,
    ST_TSUM = 12'b0000_1000_0000,
    ST_GAIN = 12'b0001_0000_0000,
    ST_GRND = 12'b0010_0000_0000,
    ST_SINE = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  // sequencer and architectural state
  state_t                 state;
  state_t                 state_next;
  state_t                 after_blep;
  pbo_pkg::shape_t        shape;
  logic [PB-1:0]          osc_phase;
  logic signed [TRI_W-1:0] tri_acc;

  // per-tick working registers
  logic [PB-1:0]          dt;
  logic [PB-1:0]          phase;
  logic signed [AW-1:0]   acc;
  logic [PB-1:0]          slot_t0;
  logic [PB-1:0]          slot_t1;
  logic [1:0]             slot_on;
  logic [1:0]             slot_neg;
  logic                   slot;
  logic                   hi_mode;
  logic                   wrap;
  logic [PLO_W-1:0]       plo;

  // result register
  logic                   out_valid;
  logic signed [SW-1:0]   out_sample;
  logic                   out_wrapped;
  logic                   out_free;

  // request decode
  logic                   accept;
  logic [PB-1:0]          dt_in;
  logic [pbo_pkg::PW_BITS-1:0] pw_c;
  logic [PB-1:0]          pwp_in;
  logic [PB-1:0]          ph_in;
  logic [PB:0]            adv;
  logic signed [AW-1:0]   ph_q;
  logic signed [AW-1:0]   pw_q;
  logic signed [AW-1:0]   base_in;
  logic [PB-1:0]          t1_in;
  logic [1:0]             on_in;
  logic [1:0]             neg_in;

  // polyblep slot evaluation
  logic [PB-1:0]          cur_t;
  logic                   near_lo;
  logic                   near_hi;
  logic                   blep_go;
  logic [QF:0]            u_val;
  logic signed [AW-1:0]   sq_term;
  logic signed [AW-1:0]   blep_val;

  // triangle and output math
  logic signed [AW-1:0]   diff;
  logic                   diff_neg;
  logic [AW-1:0]          diff_abs;
  logic [MAG_W-1:0]       mag;
  logic [PT_W-1:0]        p_tot;
  logic [RND_W-1:0]       rnd;
  logic signed [AW-1:0]   t_sum;
  logic signed [TRI_W-1:0] tri_sat;
  logic                   tri_neg;
  logic [AW-1:0]          tri_abs;
  logic [G_W-1:0]         g_val;
  logic                   acc_neg;
  logic [AW-1:0]          acc_abs;
  logic [MQ_W-1:0]        mq;
  logic signed [SW-1:0]   acc_sat;
  logic signed [SW-1:0]   sine_val;

  // shared units
  pbo_pkg::div_cmd_t      div_cmd;
  pbo_pkg::div_stat_t     div_stat;
  logic [QF-1:0]          quot;
  pbo_pkg::mul_op_t       mul_op;
  logic [2*MW-1:0]        prod;

  pbo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .stat (div_stat),
    .quot (quot)
  );

  pbo_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  pbo_sine u_sine (
    .clk   (clk),
    .phase (phase),
    .value (sine_val)
  );

  // handshakes
  assign tick.ready   = (state == ST_IDLE);
  assign accept       = tick.valid && tick.ready;
  assign cfg.ready    = 1'b1;
  assign audio.valid  = out_valid;
  assign audio.sample = out_sample;
  assign audio.phase_wrapped = out_wrapped;
  assign out_free     = !out_valid || audio.ready;

  // clamp the request, pick the phase to render, advance the phase
  always_comb begin
    dt_in = (tick.phase_increment > pbo_pkg::PH_HALF) ? pbo_pkg::PH_HALF
                                                      : tick.phase_increment;
    if (tick.pulse_width < pbo_pkg::PW_MIN) begin
      pw_c = pbo_pkg::PW_MIN;
    end else if (tick.pulse_width > pbo_pkg::PW_MAX) begin
      pw_c = pbo_pkg::PW_MAX;
    end else begin
      pw_c = tick.pulse_width;
    end
    pwp_in = PB'(pw_c) << pbo_pkg::PW_SHIFT;
    ph_in  = tick.sync_reset ? '0 : osc_phase;
    adv    = {1'b0, ph_in} + {1'b0, dt_in};
    ph_q   = $signed(AW'(ph_in) << pbo_pkg::Q_SHIFT);
    pw_q   = $signed(AW'(pwp_in) << pbo_pkg::Q_SHIFT);
  end

  // naive waveform value and the two correction slots per shape
  always_comb begin
    base_in = '0;
    t1_in   = '0;
    on_in   = 2'b00;
    neg_in  = 2'b00;
    unique case (shape)
      pbo_pkg::SHAPE_SAW: begin
        base_in = (ph_q <<< 1) - pbo_pkg::ONE_Q30;
        on_in   = 2'b01;
        neg_in  = 2'b01;
      end
      pbo_pkg::SHAPE_PULSE: begin
        base_in = (ph_in < pwp_in) ? pbo_pkg::ONE_Q30 - pw_q : -pw_q;
        t1_in   = ph_in - pwp_in;
        on_in   = 2'b11;
        neg_in  = 2'b10;
      end
      pbo_pkg::SHAPE_TRI: begin
        base_in = (ph_in < pbo_pkg::PH_HALF) ? pbo_pkg::ONE_Q30 : -pbo_pkg::ONE_Q30;
        t1_in   = ph_in + pbo_pkg::PH_HALF;
        on_in   = 2'b11;
        neg_in  = 2'b10;
      end
      pbo_pkg::SHAPE_SINE: begin
        base_in = '0;
      end
    endcase
  end

  // which side of the discontinuity the current slot sits on
  always_comb begin
    cur_t   = slot ? slot_t1 : slot_t0;
    near_lo = cur_t < dt;
    near_hi = ({1'b0, cur_t} + {1'b0, dt}) > pbo_pkg::PH_ONE;
    blep_go = slot_on[slot] && (dt != '0) && (near_lo || near_hi);

    div_cmd.start = (state == ST_SLOT) && blep_go;
    div_cmd.num   = near_lo ? cur_t : PB'(pbo_pkg::PH_ONE - {1'b0, cur_t});
    div_cmd.den   = dt;
  end

  // polyblep value from the divider quotient and its square
  always_comb begin
    u_val    = {1'b1, {QF{1'b0}}} - {1'b0, quot};
    sq_term  = $signed(AW'(prod >> QF));
    if (hi_mode) begin
      blep_val = sq_term;
    end else begin
      blep_val = $signed(AW'(quot) << 1) - sq_term - pbo_pkg::ONE_Q30;
    end
  end

  // leaky integrator step and output gain
  always_comb begin
    diff     = acc - AW'(tri_acc);
    diff_neg = diff[AW-1];
    diff_abs = diff_neg ? AW'(-diff) : AW'(diff);
    mag      = diff_abs[MAG_W-1:0];
    p_tot    = (PT_W'(prod[PB+HI_W-1:0]) << LO_W) + PT_W'(plo);
    rnd      = RND_W'((p_tot + (PT_W'(1) << (TRI_SH - 1))) >> TRI_SH);
    t_sum    = AW'(tri_acc) + (diff_neg ? -$signed(AW'(rnd)) : $signed(AW'(rnd)));
    if (t_sum > TRI_MAX) begin
      tri_sat = TRI_MAX[TRI_W-1:0];
    end else if (t_sum < TRI_MIN) begin
      tri_sat = TRI_MIN[TRI_W-1:0];
    end else begin
      tri_sat = t_sum[TRI_W-1:0];
    end
    tri_neg = tri_acc[TRI_W-1];
    tri_abs = tri_neg ? AW'(-AW'(tri_acc)) : AW'(AW'(tri_acc));
    g_val   = G_W'((prod[TRI_W+pbo_pkg::PW_BITS-1:0] + (48'd1 << (GAIN_SH - 1))) >> GAIN_SH);
  end

  // q2.30 to q1.15, half away from zero, saturated
  always_comb begin
    acc_neg = acc[AW-1];
    acc_abs = acc_neg ? AW'(-acc) : AW'(acc);
    mq      = MQ_W'((acc_abs + (AW'(1) << 14)) >> 15);
    if (acc_neg) begin
      acc_sat = (mq >= MQ_W'(32768)) ? pbo_pkg::SAMPLE_MIN : $signed(SW'(MQ_W'(0) - mq));
    end else begin
      acc_sat = (mq > MQ_W'(32767)) ? pbo_pkg::SAMPLE_MAX : $signed(mq[SW-1:0]);
    end
  end

  // shared multiplier operands by step
  always_comb begin
    mul_op = '0;
    unique case (state)
      ST_SQR: begin
        mul_op.a = hi_mode ? MW'(u_val) : MW'(quot);
        mul_op.b = hi_mode ? MW'(u_val) : MW'(quot);
      end
      ST_TLO: begin
        mul_op.a = MW'(dt);
        mul_op.b = MW'(mag[LO_W-1:0]);
      end
      ST_THI: begin
        mul_op.a = MW'(dt);
        mul_op.b = MW'(mag[MAG_W-1:LO_W]);
      end
      ST_GAIN: begin
        mul_op.a = MW'(pbo_pkg::TRI_GAIN);
        mul_op.b = tri_abs[MW-1:0];
      end
      default: mul_op = '0;
    endcase
  end

  // sequencer
  always_comb begin
    after_blep = (shape == pbo_pkg::SHAPE_TRI) ? ST_TLO : ST_DONE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick.valid) state_next = (shape == pbo_pkg::SHAPE_SINE) ? ST_SINE : ST_SLOT;
      end
      ST_SLOT: begin
        if (blep_go) state_next = ST_DIV;
        else if (slot) state_next = after_blep;
      end
      ST_DIV:  if (div_stat.done) state_next = ST_SQR;
      ST_SQR:  state_next = ST_ACC;
      ST_ACC:  state_next = slot ? after_blep : ST_SLOT;
      ST_TLO:  state_next = ST_THI;
      ST_THI:  state_next = ST_TSUM;
      ST_TSUM: state_next = ST_GAIN;
      ST_GAIN: state_next = ST_GRND;
      ST_GRND: state_next = ST_DONE;
      ST_SINE: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      shape     <= pbo_pkg::SHAPE_SAW;
      osc_phase <= '0;
      tri_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) shape <= pbo_pkg::shape_t'(cfg.data);
      if (accept) osc_phase <= adv[PB-1:0];
      if (state == ST_TSUM) tri_acc <= tri_sat;
      // a new result refills the register in the cycle the old one leaves
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (audio.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dt       <= dt_in;
      phase    <= ph_in;
      acc      <= base_in;
      slot_t0  <= ph_in;
      slot_t1  <= t1_in;
      slot_on  <= on_in;
      slot_neg <= neg_in;
      slot     <= 1'b0;
      wrap     <= adv[PB];
    end
    if (state == ST_SLOT) begin
      if (blep_go) hi_mode <= !near_lo;
      else slot <= 1'b1;
    end
    if (state == ST_ACC) begin
      acc  <= slot_neg[slot] ? acc - blep_val : acc + blep_val;
      slot <= 1'b1;
    end
    if (state == ST_THI) plo <= prod[PLO_W-1:0];
    if (state == ST_GRND) begin
      acc <= tri_neg ? -$signed(AW'(g_val)) : $signed(AW'(g_val));
    end
    if (state == ST_DONE && out_free) begin
      out_sample  <= (shape == pbo_pkg::SHAPE_SINE) ? sine_val : acc_sat;
      out_wrapped <= wrap;
    end
  end

  // the divider only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside its wait step");

  // a division is never restarted while one is running
  assert property (@(posedge clk) disable iff (rst)
    div_cmd.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // the oscillator phase moves only when a request is taken
  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> $stable(osc_phase))
    else $error("phase changed while a request is in flight");

  // an accepted request always starts work
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted request left the sequencer idle");

endmodule
